// ===== hw/rtl/thermal_alert_monitor_core_defines.svh =====
// ----------------------------------------------------------------------------
// Thermal alert monitor assertion macros
// Shared concurrent assertion forms for the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef THERMAL_ALERT_MONITOR_CORE_DEFINES_SVH
`define THERMAL_ALERT_MONITOR_CORE_DEFINES_SVH

// same-cycle implication
`define TAM_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tam_pkg.sv =====
// ----------------------------------------------------------------------------
// Thermal alert monitor package
// Widths, mode codes, register map and reset values shared by the monitor.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int DEPTH_DEF = 10;

  localparam int TEMP_W = 16;
  localparam int MODE_W = 2;
  localparam int STEP_W = 4;
  localparam int SCNT_W = 16;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALERT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CAL   = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALERT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RECOV = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = 2'd3;

  localparam logic signed [TEMP_W-1:0] START_RST = 16'sd2000;
  localparam logic signed [TEMP_W-1:0] ALERT_RST = 16'sd3000;
  localparam logic signed [TEMP_W-1:0] RECOV_RST = 16'sd2500;
  localparam logic [STEP_W-1:0]        LIMIT_RST = 4'd5;

  localparam logic [SCNT_W-1:0] SCNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [TEMP_W-1:0] start_thr;
    logic signed [TEMP_W-1:0] alert_thr;
    logic signed [TEMP_W-1:0] recov_thr;
    logic [STEP_W-1:0]        cal_limit;
  } tam_cfg_t;

endpackage

// ===== hw/rtl/tam_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tam_div.sv =====
// ----------------------------------------------------------------------------
// Thermal alert monitor divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tam_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    diff     = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      num_nxt = {num_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = num_r;

endmodule

// ===== hw/rtl/tam_cfg.sv =====
// ----------------------------------------------------------------------------
// Thermal alert monitor register file
// APB-style access to the thresholds and the calibration step limit.
// ----------------------------------------------------------------------------
module tam_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tam_pkg::APB_AW-1:0]  paddr,
  input  logic [tam_pkg::APB_DW-1:0]  pwdata,
  output logic [tam_pkg::APB_DW-1:0]  prdata,
  output tam_pkg::tam_cfg_t           cfg
);

  tam_pkg::tam_cfg_t                 cfg_r, cfg_nxt;
  logic [tam_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr;

  assign idx = paddr[tam_pkg::APB_AW-1:2];
  assign wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        tam_pkg::REG_START: cfg_nxt.start_thr = pwdata[tam_pkg::TEMP_W-1:0];
        tam_pkg::REG_ALERT: cfg_nxt.alert_thr = pwdata[tam_pkg::TEMP_W-1:0];
        tam_pkg::REG_RECOV: cfg_nxt.recov_thr = pwdata[tam_pkg::TEMP_W-1:0];
        tam_pkg::REG_LIMIT: cfg_nxt.cal_limit = pwdata[tam_pkg::STEP_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tam_pkg::REG_START: prdata = tam_pkg::APB_DW'(unsigned'(cfg_r.start_thr));
      tam_pkg::REG_ALERT: prdata = tam_pkg::APB_DW'(unsigned'(cfg_r.alert_thr));
      tam_pkg::REG_RECOV: prdata = tam_pkg::APB_DW'(unsigned'(cfg_r.recov_thr));
      tam_pkg::REG_LIMIT: prdata = tam_pkg::APB_DW'(cfg_r.cal_limit);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_thr <= tam_pkg::START_RST;
      cfg_r.alert_thr <= tam_pkg::ALERT_RST;
      cfg_r.recov_thr <= tam_pkg::RECOV_RST;
      cfg_r.cal_limit <= tam_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/thermal_alert_monitor_core.sv =====
// ----------------------------------------------------------------------------
// Thermal alert monitor core
// Four-mode temperature supervisor with a sample history ring in RAM.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one temperature sample per beat.
// Output channel out_valid/out_stall returns one result beat per sample:
// mode, average, monitor sample count, calibration step, history min/max.
// Registers sit on the APB-style port (psel..pready), 4 bytes apart.
// An accepted sample is written to the ring RAM in the accept cycle, then
// the ring is walked one entry per cycle through the RAM read port to form
// the sum, minimum and maximum. While monitoring, the mean is formed by a
// bit-serial divider over SUM_W = 16 + clog2(DEPTH) bits. One sample is in
// flight at a time and in_stall is high while it is worked on.
// The result lands in an output register; the next sample is taken while
// it waits. If the receiver stalls and the register is still full when the
// next result is done, that result and in_stall hold until the beat moves.
// Reset restores register defaults, mode idle, empty ring, no pending beat.
// ----------------------------------------------------------------------------
`include "thermal_alert_monitor_core_defines.svh"

module thermal_alert_monitor_core #(
  parameter int DEPTH = tam_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tam_pkg::TEMP_W-1:0]   in_temperature,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tam_pkg::MODE_W-1:0]          out_mode,
  output logic signed [tam_pkg::TEMP_W-1:0]   out_average,
  output logic [tam_pkg::SCNT_W-1:0]          out_monitor_samples,
  output logic [tam_pkg::STEP_W-1:0]          out_cal_step,
  output logic signed [tam_pkg::TEMP_W-1:0]   out_history_min,
  output logic signed [tam_pkg::TEMP_W-1:0]   out_history_max,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tam_pkg::APB_AW-1:0]          paddr,
  input  logic [tam_pkg::APB_DW-1:0]          pwdata,
  output logic [tam_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int TW    = tam_pkg::TEMP_W;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = TW + $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  tam_pkg::tam_cfg_t cfg;

  logic [2:0]                   state_r, state_nxt;
  logic [tam_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [IDX_W-1:0]             slot_r, slot_nxt;
  logic [CNT_W-1:0]             fill_r, fill_nxt;
  logic signed [TW-1:0]         avg_r, avg_nxt;
  logic [tam_pkg::SCNT_W-1:0]   scnt_r, scnt_nxt;
  logic [tam_pkg::STEP_W-1:0]   step_r, step_nxt;

  logic signed [TW-1:0]         t_r;
  logic [CNT_W-1:0]             n_r;
  logic [IDX_W-1:0]             last_r;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]             rd_idx_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic signed [TW-1:0]         min_r, max_r;
  logic signed [TW-1:0]         rdata;

  logic                         out_valid_r, out_valid_nxt;
  logic [tam_pkg::MODE_W-1:0]   o_mode_r;
  logic signed [TW-1:0]         o_avg_r;
  logic [tam_pkg::SCNT_W-1:0]   o_scnt_r;
  logic [tam_pkg::STEP_W-1:0]   o_step_r;
  logic signed [TW-1:0]         o_min_r, o_max_r;

  logic                         in_acc;
  logic                         commit;
  logic                         div_start, div_busy, div_done;
  logic [SUM_W-1:0]             div_num, div_quo;
  logic [SUM_W-1:0]             div_sgn;
  logic signed [TW-1:0]         avg_mon;

  assign pready = 1'b1;

  tam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  tam_ram #(
    .WIDTH (TW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (slot_r),
    .wdata (in_temperature),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign div_num = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  tam_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (n_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign div_sgn = sum_r[SUM_W-1] ? (~div_quo + 1'b1) : div_quo;
  assign avg_mon = (n_r != '0) ? div_sgn[TW-1:0] : avg_r;

  assign commit = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_vld_nxt = 1'b1;
        if (idx_r == last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (mode_r == tam_pkg::MODE_MON && n_r != '0) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // mode step
  always_comb begin
    mode_nxt = mode_r;
    avg_nxt  = avg_r;
    scnt_nxt = scnt_r;
    step_nxt = step_r;
    unique case (mode_r)
      tam_pkg::MODE_IDLE: begin
        if (t_r > cfg.start_thr) begin
          mode_nxt = tam_pkg::MODE_MON;
          avg_nxt  = t_r;
          scnt_nxt = tam_pkg::SCNT_W'(1);
        end
      end
      tam_pkg::MODE_MON: begin
        if (scnt_r != tam_pkg::SCNT_MAX) begin
          scnt_nxt = scnt_r + 1'b1;
        end
        avg_nxt = avg_mon;
        if (avg_mon > cfg.alert_thr) begin
          mode_nxt = tam_pkg::MODE_ALERT;
        end
      end
      tam_pkg::MODE_ALERT: begin
        if (t_r < cfg.recov_thr) begin
          mode_nxt = tam_pkg::MODE_CAL;
          step_nxt = tam_pkg::STEP_W'(1);
        end
      end
      tam_pkg::MODE_CAL: begin
        if ({1'b0, step_r} + 1'b1 > {1'b0, cfg.cal_limit}) begin
          mode_nxt = tam_pkg::MODE_IDLE;
          step_nxt = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: mode_nxt = mode_r;
    endcase
  end

  assign slot_nxt = (slot_r == IDX_W'(DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign fill_nxt = (fill_r == CNT_W'(DEPTH)) ? fill_r : fill_r + 1'b1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= tam_pkg::MODE_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      avg_r       <= '0;
      scnt_r      <= '0;
      step_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
      end
      if (commit) begin
        mode_r <= mode_nxt;
        avg_r  <= avg_nxt;
        scnt_r <= scnt_nxt;
        step_r <= step_nxt;
      end
    end
  end

  // sample latch, ring walk and result register
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rd_idx_r <= idx_r;
    if (in_acc) begin
      t_r    <= in_temperature;
      n_r    <= fill_r;
      last_r <= (fill_r < CNT_W'(DEPTH)) ? IDX_W'(fill_r) : IDX_W'(DEPTH - 1);
      sum_r  <= '0;
    end else if (rd_vld_r) begin
      if (CNT_W'(rd_idx_r) < n_r) begin
        sum_r <= sum_r + SUM_W'(rdata);
      end
      if (rd_idx_r == '0 || rdata < min_r) begin
        min_r <= rdata;
      end
      if (rd_idx_r == '0 || rdata > max_r) begin
        max_r <= rdata;
      end
    end
    if (commit) begin
      o_mode_r <= mode_nxt;
      o_avg_r  <= (mode_nxt == tam_pkg::MODE_MON) ? avg_nxt : '0;
      o_scnt_r <= (mode_nxt == tam_pkg::MODE_MON) ? scnt_nxt : '0;
      o_step_r <= (mode_nxt == tam_pkg::MODE_CAL) ? step_nxt : '0;
      o_min_r  <= min_r;
      o_max_r  <= max_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mode             = o_mode_r;
  assign out_average          = o_avg_r;
  assign out_monitor_samples  = o_scnt_r;
  assign out_cal_step         = o_step_r;
  assign out_history_min      = o_min_r;
  assign out_history_max      = o_max_r;

  `TAM_ASSERT_NEXT(a_accept_walk, clk, rst_n, in_acc, state_r == ST_WALK, "beat accepted without ring walk")
  `TAM_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= CNT_W'(DEPTH), "fill count beyond ring depth")
  `TAM_ASSERT_NOW(a_step_mode, clk, rst_n, mode_r != tam_pkg::MODE_CAL, step_r == '0, "step set outside calibrating")
  `TAM_ASSERT_NOW(a_div_owner, clk, rst_n, div_busy, state_r == ST_DIV, "divider busy outside divide state")
  `TAM_ASSERT_NEXT(a_fin_hold, clk, rst_n, state_r == ST_FIN && out_valid_r && out_stall, state_r == ST_FIN, "result left while output full")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Thermal alert monitor testbench
// Drives temperature samples into thermal_alert_monitor_core and checks each
// result beat against an in-bench model of the four-mode supervisor and its
// sample ring. Random input gaps and output stalls, register changes between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TEMP_W      = tam_pkg::TEMP_W;
  localparam int MODE_W      = tam_pkg::MODE_W;
  localparam int SCNT_W      = tam_pkg::SCNT_W;
  localparam int STEP_W      = tam_pkg::STEP_W;
  localparam int APB_AW      = tam_pkg::APB_AW;
  localparam int APB_DW      = tam_pkg::APB_DW;
  localparam int REG_IDX_W   = tam_pkg::REG_IDX_W;

  localparam int RING_N      = tam_pkg::DEPTH_DEF;
  localparam int SETTLE      = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic signed [TEMP_W-1:0] average;
    logic [SCNT_W-1:0]        samples;
    logic [STEP_W-1:0]        step;
    logic signed [TEMP_W-1:0] lo;
    logic signed [TEMP_W-1:0] hi;
  } status_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [TEMP_W-1:0]  in_temperature = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [MODE_W-1:0]         out_mode;
  logic signed [TEMP_W-1:0]  out_average;
  logic [SCNT_W-1:0]         out_monitor_samples;
  logic [STEP_W-1:0]         out_cal_step;
  logic signed [TEMP_W-1:0]  out_history_min;
  logic signed [TEMP_W-1:0]  out_history_max;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_AW-1:0]         paddr = '0;
  logic [APB_DW-1:0]         pwdata = '0;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  thermal_alert_monitor_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_temperature       (in_temperature),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_mode             (out_mode),
    .out_average          (out_average),
    .out_monitor_samples  (out_monitor_samples),
    .out_cal_step         (out_cal_step),
    .out_history_min      (out_history_min),
    .out_history_max      (out_history_max),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // supervisor model state and its copy of the registers
  logic signed [TEMP_W-1:0] thr_start = tam_pkg::START_RST;
  logic signed [TEMP_W-1:0] thr_alert = tam_pkg::ALERT_RST;
  logic signed [TEMP_W-1:0] thr_recov = tam_pkg::RECOV_RST;
  logic [STEP_W-1:0]        cal_limit = tam_pkg::LIMIT_RST;
  logic [MODE_W-1:0]        sv_mode = tam_pkg::MODE_IDLE;
  logic signed [TEMP_W-1:0] ring_copy [RING_N];
  int                       write_slot = 0;
  int                       fill = 0;
  int                       run_avg = 0;
  int                       monitor_count = 0;
  int                       cal_step = 0;

  logic signed [TEMP_W-1:0] sample_q [$];
  status_t                  expected_status [$];
  logic                     in_took = 1'b0;
  logic                     calm = 1'b0;
  int                       hold_asked = 0;
  int                       queued_total = 0;
  int                       err_count = 0;
  int                       beat_no = 0;
  int                       cycle_no = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic status_t advance_supervisor(logic signed [TEMP_W-1:0] t);
    int      n;
    int      i;
    longint  sum;
    status_t s;
    n = fill;
    if (write_slot >= RING_N) write_slot = 0;
    ring_copy[write_slot] = t;
    write_slot = (write_slot + 1 >= RING_N) ? 0 : write_slot + 1;
    if (fill < RING_N) fill++;
    case (sv_mode)
      tam_pkg::MODE_IDLE: begin
        if (t > thr_start) begin
          sv_mode = tam_pkg::MODE_MON;
          run_avg = t;
          monitor_count = 1;
        end
      end
      tam_pkg::MODE_MON: begin
        if (monitor_count < 65535) monitor_count++;
        if (n > 0 && n <= RING_N) begin
          sum = 0;
          for (i = 0; i < n; i++) sum += ring_copy[i];
          run_avg = int'(sum / n);
        end
        if (run_avg > int'(thr_alert)) sv_mode = tam_pkg::MODE_ALERT;
      end
      tam_pkg::MODE_ALERT: begin
        if (t < thr_recov) begin
          sv_mode = tam_pkg::MODE_CAL;
          cal_step = 1;
        end
      end
      default: begin
        if (cal_step + 1 > int'(cal_limit)) begin
          sv_mode = tam_pkg::MODE_IDLE;
          cal_step = 0;
        end else begin
          cal_step = (cal_step + 1) & 15;
        end
      end
    endcase
    s.lo = ring_copy[0];
    s.hi = ring_copy[0];
    for (i = 1; i < fill; i++) begin
      if (ring_copy[i] < s.lo) s.lo = ring_copy[i];
      if (ring_copy[i] > s.hi) s.hi = ring_copy[i];
    end
    s.mode    = sv_mode;
    s.average = (sv_mode == tam_pkg::MODE_MON) ? TEMP_W'(run_avg) : '0;
    s.samples = (sv_mode == tam_pkg::MODE_MON) ? SCNT_W'(monitor_count) : '0;
    s.step    = (sv_mode == tam_pkg::MODE_CAL) ? STEP_W'(cal_step) : '0;
    return s;
  endfunction

  function automatic int pick_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic signed [TEMP_W-1:0] pick_around(int base, int off_lo, int off_hi);
    int v;
    v = base + off_lo + int'($urandom_range(0, off_hi - off_lo));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return TEMP_W'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at beat %0d, %s: got %0d, expected %0d", beat_no, what, got, want);
    err_count++;
  endtask

  task automatic push_sample(logic signed [TEMP_W-1:0] t);
    sample_q.push_back(t);
    queued_total++;
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(int s, int a, int r, int lim);
    write_reg(tam_pkg::REG_START, {16'h0000, 16'(s)});
    write_reg(tam_pkg::REG_ALERT, {16'h0000, 16'(a)});
    write_reg(tam_pkg::REG_RECOV, {16'h0000, 16'(r)});
    write_reg(tam_pkg::REG_LIMIT, {28'h0, 4'(lim)});
    thr_start = 16'(s);
    thr_alert = 16'(a);
    thr_recov = 16'(r);
    cal_limit = 4'(lim);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // most episodes aim to walk idle -> monitoring -> alert -> calibrating -> idle; one in five is a random burst
  task automatic run_phase(int count, bit calm_on, bit hold_on);
    int first;
    first = queued_total;
    calm = calm_on;
    if (hold_on) hold_asked++;
    while (queued_total - first < count) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) push_sample(TEMP_W'($urandom_range(0, 65535)));
      end else begin
        repeat ($urandom_range(0, 3)) push_sample(pick_around(thr_start, -1200, 0));
        push_sample(pick_around(thr_start, 1, 2000));
        repeat ($urandom_range(6, 14)) push_sample(pick_around(thr_alert, 1, 4000));
        repeat ($urandom_range(0, 3)) push_sample(pick_around(thr_recov, 0, 2000));
        push_sample(pick_around(thr_recov, -2000, -1));
        repeat (int'(cal_limit) + $urandom_range(0, 2))
          push_sample(TEMP_W'($urandom_range(0, 65535)));
      end
    end
    wait_idle();
  endtask

  // check result beats, then advance the model on accepted samples
  always @(posedge clk) begin : check_p
    status_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        report_mismatch("result with nothing pending, mode", out_mode, 0);
      end else begin
        want = expected_status.pop_front();
        if (out_mode !== want.mode) report_mismatch("mode", out_mode, want.mode);
        if (out_average !== want.average)
          report_mismatch("average", out_average, want.average);
        if (out_monitor_samples !== want.samples)
          report_mismatch("monitor_samples", out_monitor_samples, want.samples);
        if (out_cal_step !== want.step)
          report_mismatch("cal_step", out_cal_step, want.step);
        if (out_history_min !== want.lo) report_mismatch("history_min", out_history_min, want.lo);
        if (out_history_max !== want.hi) report_mismatch("history_max", out_history_max, want.hi);
      end
      beat_no++;
    end
    if (rst_n && in_valid && !in_stall)
      expected_status.push_back(advance_supervisor(in_temperature));
  end

  // sample driver
  always @(negedge clk) begin : drive_p
    logic                     nv;
    logic signed [TEMP_W-1:0] nt;
    int                       send_gap;
    nv = in_valid;
    nt = in_temperature;
    if (in_took) nv = 1'b0;
    if (!nv) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (sample_q.size() != 0) begin
        nv = 1'b1;
        nt = sample_q.pop_front();
        send_gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap_len();
      end
    end
    in_valid       <= nv;
    in_temperature <= nt;
  end

  // result back-pressure
  always @(negedge clk) begin : stall_p
    int   hold_served;
    int   hold_left;
    int   stall_left;
    logic ns;
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else if (calm) begin
      stall_left = 0;
      ns = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap_len() - 1;
      ns = 1'b1;
    end else begin
      ns = 1'b0;
    end
    out_stall <= ns;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus_p
    int first_vals [16];
    int k;
    int s;
    int a;
    int r;
    int lim;
    first_vals = '{-32768, 32767, -1, 32767, 2500, 2500, 2499, 0, 0, 0, 0, 0,
                   2000, 2001, 16'h5555, 16'hAAAA};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    apply_settings(tam_pkg::START_RST, tam_pkg::ALERT_RST, tam_pkg::RECOV_RST,
                   tam_pkg::LIMIT_RST);
    foreach (first_vals[i]) push_sample(TEMP_W'(first_vals[i]));
    wait_idle();

    run_phase(200, 1'b0, 1'b1);
    apply_settings(-32768, -32768, 32767, 0);
    run_phase(100, 1'b0, 1'b0);
    apply_settings(32767, 32767, -32768, 15);
    run_phase(60, 1'b1, 1'b0);
    apply_settings(tam_pkg::START_RST, tam_pkg::ALERT_RST, tam_pkg::RECOV_RST, 15);
    run_phase(150, 1'b0, 1'b0);
    for (k = 0; k < 8; k++) begin
      s = int'($urandom_range(0, 8000)) - 4000;
      a = s + int'($urandom_range(0, 3000));
      r = a - int'($urandom_range(0, 3000));
      lim = (k == 0) ? 0 : (k == 1) ? 15 : int'($urandom_range(1, 14));
      apply_settings(s, a, r, lim);
      run_phase(100, k == 3, k == 5);
    end

    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== thermal_alert_monitor_core.f =====
+incdir+hw/rtl
hw/rtl/tam_pkg.sv
hw/rtl/tam_ram.sv
hw/rtl/tam_div.sv
hw/rtl/tam_cfg.sv
hw/rtl/thermal_alert_monitor_core.sv
dv/tb_top.sv
